### rtl/pdsc_pkg.sv
// Shared types and constants for the source-capabilities power selector.
// Used by every module of the block; depends on nothing.

package pdsc_pkg;

	localparam int unsigned MAX_OBJECTS_DEF = 7;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [15:0] LIMIT_RESET_MV = 16'd24000;

	// PDO type codes (bits 31:30) and augmented subtype (bits 29:28)
	localparam logic [1:0] PDO_TYPE_FIXED = 2'b00;
	localparam logic [1:0] PDO_TYPE_APDO  = 2'b11;
	localparam logic [1:0] APDO_SUB_PPS   = 2'b00;

	typedef struct packed {
		logic [31:0] pdo_word;
		logic        last_object;
	} pdo_in_t;

	typedef struct packed {
		logic        found;
		logic [31:0] request_word;
		logic [2:0]  object_position;
		logic [15:0] chosen_voltage_mv;
		logic [13:0] chosen_current_ma;
		logic        chosen_is_pps;
	} rdo_out_t;

	// Decoded object: body holds request bits 20:0 ready for the RDO
	typedef struct packed {
		logic        usable;
		logic        last;
		logic [2:0]  pos;
		logic [15:0] mv;
		logic [13:0] ma;
		logic        pps;
		logic [20:0] body;
	} dec_t;

	typedef struct packed {
		dec_t        dec;
		logic [29:0] power;
	} cand_t;

endpackage

### rtl/pdsc_front.sv
// Front end: limit register, object counter, PDO decode and power product.
// Depends on pdsc_pkg; feeds candidates to the queue.

module pdsc_front import pdsc_pkg::*; #(
	parameter int unsigned MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic    pdo_valid,
	output logic    pdo_stall,
	input  pdo_in_t pdo_data,
	output logic    cand_push,
	output cand_t   cand_data,
	input  logic    queue_full
);

	logic [15:0] limit_q;
	logic [2:0]  count_q;
	logic        valid_s1, valid_s2;
	dec_t        dec_s1;
	cand_t       cand_s2;

	logic        adv_s1, adv_s2, accept, consider;
	logic [1:0]  ptype, psub;
	logic        fixed, pps;
	logic [15:0] mv;
	logic [13:0] ma;
	logic [20:0] body;
	logic [9:0]  fix_ma_code;
	logic [11:0] pps_v20;
	dec_t        dec_n;

	assign adv_s2    = !valid_s2 || !queue_full;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign pdo_stall = !adv_s1;
	assign accept    = pdo_valid && adv_s1;
	assign cand_push = valid_s2 && !queue_full;
	assign cand_data = cand_s2;

	assign consider = count_q < 3'(MAX_OBJECTS);

	always_comb begin
		ptype       = pdo_data.pdo_word[31:30];
		psub        = pdo_data.pdo_word[29:28];
		fixed       = ptype == PDO_TYPE_FIXED;
		pps         = (ptype == PDO_TYPE_APDO) && (psub == APDO_SUB_PPS);
		fix_ma_code = pdo_data.pdo_word[9:0];
		pps_v20     = 12'(pdo_data.pdo_word[24:17]) * 12'd5;
		if (pps) begin
			mv   = 16'(pdo_data.pdo_word[24:17]) * 16'd100;
			ma   = 14'(pdo_data.pdo_word[6:0]) * 14'd50;
			body = {pps_v20, 2'b00, pdo_data.pdo_word[6:0]};
		end else begin
			mv   = 16'(pdo_data.pdo_word[19:10]) * 16'd50;
			ma   = 14'(fix_ma_code) * 14'd10;
			body = {1'b0, fix_ma_code, fix_ma_code};
		end
		dec_n.usable = (fixed || pps) && consider && (mv <= limit_q);
		dec_n.last   = pdo_data.last_object;
		dec_n.pos    = count_q + 3'd1;
		dec_n.mv     = mv;
		dec_n.ma     = ma;
		dec_n.pps    = pps;
		dec_n.body   = body;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET_MV;
			count_q  <= 3'd0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (accept) begin
				// restart the position count at each message boundary
				if (pdo_data.last_object) begin
					count_q <= 3'd0;
				end else if (consider) begin
					count_q <= count_q + 3'd1;
				end
			end
			if (adv_s1) begin
				valid_s1 <= accept;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec_n;
		end
		if (adv_s2 && valid_s1) begin
			cand_s2.dec   <= dec_s1;
			cand_s2.power <= {14'd0, dec_s1.mv} * {16'd0, dec_s1.ma};
		end
	end

endmodule

### rtl/pdsc_queue.sv
// Small FIFO of decoded candidates between front and back.
// Depends on pdsc_pkg for the entry type.

module pdsc_queue import pdsc_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cand_t push_data,
	output logic  full,
	input  logic  pop,
	output cand_t head,
	output logic  nonempty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cand_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign full     = count_q == CW'(DEPTH);
	assign nonempty = count_q != '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### rtl/pdsc_back.sv
// Back end: running-best compare, request word assembly and result register.
// Depends on pdsc_pkg; drains the candidate queue.

module pdsc_back import pdsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     nonempty,
	input  cand_t    head,
	output logic     pop,
	output logic     rdo_valid,
	input  logic     rdo_stall,
	output rdo_out_t rdo_data
);

	logic [29:0] best_power_q;
	logic [2:0]  best_pos_q;
	logic [15:0] best_mv_q;
	logic [13:0] best_ma_q;
	logic        best_pps_q;
	logic [20:0] best_body_q;
	logic        have_q;
	logic        out_valid_q;
	rdo_out_t    out_q;

	logic        out_free, take;
	logic [29:0] n_power;
	logic [2:0]  n_pos;
	logic [15:0] n_mv;
	logic [13:0] n_ma;
	logic        n_pps, n_have;
	logic [20:0] n_body;
	rdo_out_t    res;

	assign out_free  = !out_valid_q || !rdo_stall;
	// hold a closing object until the result register is free
	assign pop       = nonempty && (!head.dec.last || out_free);
	assign take      = head.dec.usable && (head.power > best_power_q);
	assign rdo_valid = out_valid_q;
	assign rdo_data  = out_q;

	always_comb begin
		n_power = take ? head.power    : best_power_q;
		n_pos   = take ? head.dec.pos  : best_pos_q;
		n_mv    = take ? head.dec.mv   : best_mv_q;
		n_ma    = take ? head.dec.ma   : best_ma_q;
		n_pps   = take ? head.dec.pps  : best_pps_q;
		n_body  = take ? head.dec.body : best_body_q;
		n_have  = take || have_q;
		res     = '0;
		if (n_have) begin
			res.found             = 1'b1;
			res.request_word      = {1'b0, n_pos, 2'b00, 1'b1, 1'b1, 3'b000, n_body};
			res.object_position   = n_pos;
			res.chosen_voltage_mv = n_mv;
			res.chosen_current_ma = n_ma;
			res.chosen_is_pps     = n_pps;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_power_q <= '0;
			best_pos_q   <= '0;
			best_mv_q    <= '0;
			best_ma_q    <= '0;
			best_pps_q   <= 1'b0;
			best_body_q  <= '0;
			have_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop && head.dec.last) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head.dec.last) begin
					best_power_q <= '0;
					best_pos_q   <= '0;
					best_mv_q    <= '0;
					best_ma_q    <= '0;
					best_pps_q   <= 1'b0;
					best_body_q  <= '0;
					have_q       <= 1'b0;
				end else begin
					best_power_q <= n_power;
					best_pos_q   <= n_pos;
					best_mv_q    <= n_mv;
					best_ma_q    <= n_ma;
					best_pps_q   <= n_pps;
					best_body_q  <= n_body;
					have_q       <= n_have;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.dec.last) begin
			out_q <= res;
		end
	end

endmodule

### rtl/pd_source_cap_best_power_request_unit.sv
// Takes source-capabilities PDOs one per cycle while not stalled and returns, per
// message, the highest-power fixed or PPS object at or under the voltage limit as
// a request word. One object is accepted every cycle when nothing downstream
// stalls. The edge that takes the last object loads the decode stage; then come
// the 16x14 power multiply register, the candidate queue, and the result register
// loaded through the combinational compare in the back end. The queue of
// QUEUE_DEPTH entries absorbs result stalls; the front stalls only once it fills.
// Depends on pdsc_pkg, pdsc_front, pdsc_queue and pdsc_back.

module pd_source_cap_best_power_request_unit import pdsc_pkg::*; #(
	parameter int unsigned MAX_OBJECTS = MAX_OBJECTS_DEF,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        pdo_valid,
	output logic        pdo_stall,
	input  pdo_in_t     pdo_data,
	output logic        rdo_valid,
	input  logic        rdo_stall,
	output rdo_out_t    rdo_data
);

	logic  cand_push, queue_full, queue_pop, queue_nonempty;
	cand_t cand_data, queue_head;

	pdsc_front #(
		.MAX_OBJECTS(MAX_OBJECTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pdo_valid (pdo_valid),
		.pdo_stall (pdo_stall),
		.pdo_data  (pdo_data),
		.cand_push (cand_push),
		.cand_data (cand_data),
		.queue_full(queue_full)
	);

	pdsc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cand_push),
		.push_data(cand_data),
		.full     (queue_full),
		.pop      (queue_pop),
		.head     (queue_head),
		.nonempty (queue_nonempty)
	);

	pdsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (queue_nonempty),
		.head     (queue_head),
		.pop      (queue_pop),
		.rdo_valid(rdo_valid),
		.rdo_stall(rdo_stall),
		.rdo_data (rdo_data)
	);

endmodule

### rtl/pdsc_checker.sv
// Port-level checks on the selector's results, bound to the top level.
// Depends on pdsc_pkg for the result struct.

module pdsc_checker import pdsc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     rdo_valid,
	input logic     rdo_stall,
	input rdo_out_t rdo_data
);

	// hold a stalled request steady
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rdo_valid && rdo_stall |=> rdo_valid && $stable(rdo_data))
		else $error("stalled request changed or dropped");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rdo_valid && !rdo_data.found |-> rdo_data.request_word == 32'd0 &&
		rdo_data.object_position == 3'd0 && rdo_data.chosen_current_ma == 14'd0)
		else $error("empty request carries data");

	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		rdo_valid && rdo_data.found |-> rdo_data.object_position != 3'd0 &&
		rdo_data.request_word[30:28] == rdo_data.object_position &&
		rdo_data.request_word[25:24] == 2'b11)
		else $error("request position or flags wrong");

	a_fixed_currents: assert property (@(posedge clk) disable iff (!arst_n)
		rdo_valid && rdo_data.found && !rdo_data.chosen_is_pps |->
		rdo_data.request_word[19:10] == rdo_data.request_word[9:0])
		else $error("fixed request currents differ");

endmodule

bind pd_source_cap_best_power_request_unit pdsc_checker u_pdsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rdo_valid(rdo_valid),
	.rdo_stall(rdo_stall),
	.rdo_data (rdo_data)
);

### dv/pd_source_cap_best_power_request_unit_tb.sv
// Self-checking testbench for pd_source_cap_best_power_request_unit: drives PDO requests,
// predicts the selected request data object per message and checks every result.
// Depends on pdsc_pkg and the unit's RTL.

module pd_source_cap_best_power_request_unit_tb import pdsc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned MAX_PRINTED = 50;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_we = 1'b0;
	logic     [15:0] cfg_wdata = '0;
	logic     pdo_valid = 1'b0;
	logic     pdo_stall;
	pdo_in_t  pdo_data = '0;
	logic     rdo_valid;
	logic     rdo_stall = 1'b0;
	rdo_out_t rdo_data;

	pd_source_cap_best_power_request_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pdo_valid (pdo_valid),
		.pdo_stall (pdo_stall),
		.pdo_data  (pdo_data),
		.rdo_valid (rdo_valid),
		.rdo_stall (rdo_stall),
		.rdo_data  (rdo_data)
	);

	// Selection state mirrored from the block
	logic [15:0] limit_mv = LIMIT_RESET_MV;
	logic [29:0] sel_power = '0;
	logic [2:0]  sel_pos = '0;
	logic [15:0] sel_mv = '0;
	logic [13:0] sel_ma = '0;
	logic        sel_pps = 1'b0;
	logic        sel_valid = 1'b0;
	logic [2:0]  obj_count = '0;

	pdo_in_t  pdo_pending[$];
	rdo_out_t rdo_expected[$];
	rdo_out_t rdo_want;

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned hold_token = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned mode_left = 0;
	int unsigned stall_mode = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < MAX_PRINTED)
			$display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Fold one request into the running selection; on a last object emit the result
	task automatic predict_selection(input pdo_in_t req);
		logic [15:0] mv;
		logic [13:0] ma;
		logic        pps;
		logic        usable;
		logic [31:0] power;
		logic [15:0] volt20;
		logic [13:0] cur;
		rdo_out_t    res;
		mv = '0;
		ma = '0;
		pps = 1'b0;
		usable = 1'b0;
		if (obj_count < 3'(MAX_OBJECTS_DEF)) begin
			if (req.pdo_word[31:30] == PDO_TYPE_FIXED) begin
				mv = 16'(req.pdo_word[19:10]) * 16'd50;
				ma = 14'(req.pdo_word[9:0]) * 14'd10;
				usable = 1'b1;
			end else if (req.pdo_word[31:30] == PDO_TYPE_APDO &&
					req.pdo_word[29:28] == APDO_SUB_PPS) begin
				mv = 16'(req.pdo_word[24:17]) * 16'd100;
				ma = 14'(req.pdo_word[6:0]) * 14'd50;
				pps = 1'b1;
				usable = 1'b1;
			end
			power = 32'(mv) * 32'(ma);
			if (usable && mv <= limit_mv && power > 32'(sel_power)) begin
				sel_power = power[29:0];
				sel_pos = obj_count + 3'd1;
				sel_mv = mv;
				sel_ma = ma;
				sel_pps = pps;
				sel_valid = 1'b1;
			end
			obj_count = obj_count + 3'd1;
		end
		if (req.last_object) begin
			res = '0;
			if (sel_valid) begin
				res.found = 1'b1;
				res.request_word = {1'b0, sel_pos, 2'b00, 1'b1, 1'b1, 24'd0};
				if (sel_pps) begin
					volt20 = sel_mv / 16'd20;
					cur = sel_ma / 14'd50;
					res.request_word[20:9] = volt20[11:0];
					res.request_word[6:0] = cur[6:0];
				end else begin
					cur = sel_ma / 14'd10;
					res.request_word[19:10] = cur[9:0];
					res.request_word[9:0] = cur[9:0];
				end
				res.object_position = sel_pos;
				res.chosen_voltage_mv = sel_mv;
				res.chosen_current_ma = sel_ma;
				res.chosen_is_pps = sel_pps;
			end
			rdo_expected.push_back(res);
			sel_power = '0;
			sel_pos = '0;
			sel_mv = '0;
			sel_ma = '0;
			sel_pps = 1'b0;
			sel_valid = 1'b0;
			obj_count = '0;
		end
	endtask

	// Sender: bursts of random length separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (!pdo_valid || !pdo_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					pdo_valid <= 1'b0;
				end else if (pdo_pending.size() != 0) begin
					pdo_data <= pdo_pending.pop_front();
					pdo_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					pdo_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern changes mode now and then; a hold request forces a long hold
	always @(posedge clk) begin
		if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			rdo_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rdo_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode_left <= $urandom_range(20, 200);
				stall_mode <= $urandom_range(0, 3);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: rdo_stall <= 1'b0;
				1: rdo_stall <= ($urandom_range(0, 3) == 0);
				2: rdo_stall <= $urandom_range(0, 1);
				default: rdo_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pdo_valid && !pdo_stall)
				predict_selection(pdo_data);
			if (rdo_valid && !rdo_stall) begin
				if (rdo_expected.size() == 0) begin
					report_mismatch("unexpected result", rdo_data.request_word, '0);
				end else begin
					rdo_want = rdo_expected.pop_front();
					if (rdo_data.found !== rdo_want.found)
						report_mismatch("found", 32'(rdo_data.found), 32'(rdo_want.found));
					if (rdo_data.request_word !== rdo_want.request_word)
						report_mismatch("request_word", rdo_data.request_word,
							rdo_want.request_word);
					if (rdo_data.object_position !== rdo_want.object_position)
						report_mismatch("object_position", 32'(rdo_data.object_position),
							32'(rdo_want.object_position));
					if (rdo_data.chosen_voltage_mv !== rdo_want.chosen_voltage_mv)
						report_mismatch("chosen_voltage_mv", 32'(rdo_data.chosen_voltage_mv),
							32'(rdo_want.chosen_voltage_mv));
					if (rdo_data.chosen_current_ma !== rdo_want.chosen_current_ma)
						report_mismatch("chosen_current_ma", 32'(rdo_data.chosen_current_ma),
							32'(rdo_want.chosen_current_ma));
					if (rdo_data.chosen_is_pps !== rdo_want.chosen_is_pps)
						report_mismatch("chosen_is_pps", 32'(rdo_data.chosen_is_pps),
							32'(rdo_want.chosen_is_pps));
				end
			end
		end
	end

	function automatic logic [31:0] fixed_pdo(input int unsigned v50, input int unsigned i10);
		logic [31:0] w;
		w = '0;
		w[31:30] = PDO_TYPE_FIXED;
		w[19:10] = 10'(v50);
		w[9:0] = 10'(i10);
		return w;
	endfunction

	function automatic logic [31:0] pps_pdo(input int unsigned v100, input int unsigned i50);
		logic [31:0] w;
		w = '0;
		w[31:30] = PDO_TYPE_APDO;
		w[29:28] = APDO_SUB_PPS;
		w[24:17] = 8'(v100);
		w[6:0] = 7'(i50);
		return w;
	endfunction

	function automatic logic [31:0] random_pdo();
		logic [31:0] w;
		int unsigned pick;
		int unsigned top;
		w = $urandom;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			w[31:30] = PDO_TYPE_FIXED;
			// keep about half of the voltages near or under the limit
			if ($urandom_range(0, 1)) begin
				top = limit_mv / 50 + 1;
				w[19:10] = 10'($urandom_range(0, (top > 1023) ? 1023 : top));
			end
			if ($urandom_range(0, 15) == 0)
				w[9:0] = '0;
		end else if (pick < 8) begin
			w[31:30] = PDO_TYPE_APDO;
			w[29:28] = APDO_SUB_PPS;
			if ($urandom_range(0, 1)) begin
				top = limit_mv / 100 + 1;
				w[24:17] = 8'($urandom_range(0, (top > 255) ? 255 : top));
			end
			if ($urandom_range(0, 15) == 0)
				w[6:0] = '0;
		end
		return w;
	endfunction

	task automatic push_request(input logic [31:0] word, input logic last);
		pdo_in_t req;
		req.pdo_word = word;
		req.last_object = last;
		pdo_pending.push_back(req);
	endtask

	task automatic queue_random_messages(input int unsigned n_items, input int unsigned max_len);
		int unsigned left;
		int unsigned len;
		left = n_items;
		while (left != 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) :
				$urandom_range(1, max_len);
			if (len > left)
				len = left;
			for (int unsigned k = 1; k <= len; k++)
				push_request(random_pdo(), k == len);
			left -= len;
		end
	endtask

	// Hold until every request is taken and every result has come back;
	// look between edges so that the sender's updates have settled
	task automatic wait_drained();
		while (pdo_pending.size() != 0 || pdo_valid || rdo_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		limit_mv = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed messages at the reset limit
		push_request(fixed_pdo(100, 300), 1'b1);
		push_request(32'h4ABC_1234, 1'b0);
		push_request(32'h8000_1234, 1'b0);
		push_request(32'hD000_0000 | pps_pdo(50, 40), 1'b1);
		push_request(fixed_pdo(100, 0), 1'b0);
		push_request(pps_pdo(0, 20), 1'b1);
		push_request(fixed_pdo(100, 200), 1'b0);
		push_request(fixed_pdo(200, 100), 1'b0);
		push_request(pps_pdo(210, 127), 1'b0);
		push_request(fixed_pdo(0, 1023), 1'b1);
		// equal power: the earlier object wins
		push_request(fixed_pdo(100, 200), 1'b0);
		push_request(fixed_pdo(200, 100), 1'b1);
		// exactly at the limit is kept, just over it is dropped
		push_request(fixed_pdo(480, 1023), 1'b0);
		push_request(fixed_pdo(481, 1023), 1'b0);
		push_request(pps_pdo(240, 127), 1'b1);
		// objects past the seventh are ignored, the last flag still closes the message
		for (int unsigned k = 1; k <= 7; k++)
			push_request(fixed_pdo(20, 10), 1'b0);
		push_request(fixed_pdo(400, 500), 1'b0);
		push_request(fixed_pdo(400, 600), 1'b1);
		push_request(32'hFFFF_FFFF, 1'b0);
		push_request(32'h0000_0000, 1'b1);

		queue_random_messages(300, 7);

		write_limit(16'd0);
		queue_random_messages(100, 7);

		write_limit(16'd51150);
		// long receiver hold while single-object messages pile up
		hold_token <= hold_token + 1;
		for (int unsigned k = 0; k < 80; k++)
			push_request(random_pdo(), 1'b1);
		queue_random_messages(220, 7);

		write_limit(16'($urandom_range(1, 51149)));
		queue_random_messages(300, 7);

		write_limit(16'd5000);
		queue_random_messages(150, 3);

		write_limit(16'($urandom_range(1, 51149)));
		queue_random_messages(250, 7);

		write_limit(LIMIT_RESET_MV);
		queue_random_messages(200, 7);

		wait_drained();
		repeat (20) @(posedge clk);
		if (rdo_expected.size() != 0)
			report_mismatch("results missing", '0, 32'(rdo_expected.size()));
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/pdsc_pkg.sv
rtl/pdsc_front.sv
rtl/pdsc_queue.sv
rtl/pdsc_back.sv
rtl/pd_source_cap_best_power_request_unit.sv
rtl/pdsc_checker.sv
dv/pd_source_cap_best_power_request_unit_tb.sv
